/* rtl/lrupr_pkg.sv */
`default_nettype none

package lrupr_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int FIU_W       = 5;
    localparam int WATCH_W     = 16;
    localparam int PAGE_IN_W   = 16;
    localparam int FRAME_OUT_W = 4;
    localparam int COUNT_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES_IN_USE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_WATCHED_PAGE  = CFG_INDEX_W'(1);

    localparam logic [FIU_W-1:0]   FIU_RESET   = FIU_W'(16);
    localparam logic [WATCH_W-1:0] WATCH_RESET = WATCH_W'(156);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic issue;
        logic commit;
    } table_ctrl_t;

endpackage

`default_nettype wire

/* rtl/lrupr_table.sv */
`default_nettype none

module lrupr_table #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16,
    parameter int IDX_W     = 4
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire lrupr_pkg::table_ctrl_t ctrl,
    input  wire  [IDX_W-1:0]         rd_addr,
    input  wire  [PAGE_BITS-1:0]     page,
    output logic                     res_hit,
    output logic [IDX_W-1:0]         res_frame
);

    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [PAGE_BITS-1:0] rd_data_reg;

    logic                 chk_valid_reg;
    logic [IDX_W-1:0]     chk_idx_reg;

    logic [FRAMES-1:0]    valid_reg;
    logic [IDX_W-1:0]     rank_reg [FRAMES];

    logic                 hit_found_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [IDX_W-1:0]     hit_rank_reg;
    logic                 empty_found_reg;
    logic [IDX_W-1:0]     empty_idx_reg;
    logic [IDX_W-1:0]     oldest_rank_reg;
    logic [IDX_W-1:0]     oldest_idx_reg;

    logic                 chk_entry_valid;
    logic [IDX_W-1:0]     chk_rank;
    logic                 chk_match;
    logic                 age_all;
    logic [IDX_W-1:0]     old_rank;
    logic [IDX_W-1:0]     frame_sel;

    // Page store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.commit && !hit_found_reg)
        begin
            page_mem[frame_sel] <= page;
        end
        rd_data_reg <= page_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
        end
        else
        begin
            chk_valid_reg <= ctrl.issue;
            chk_idx_reg   <= rd_addr;
        end
    end

    assign chk_entry_valid = valid_reg[chk_idx_reg];
    assign chk_rank        = rank_reg[chk_idx_reg];
    assign chk_match       = chk_entry_valid && (rd_data_reg == page);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg   <= 1'b0;
            hit_idx_reg     <= '0;
            hit_rank_reg    <= '0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
            oldest_rank_reg <= '0;
            oldest_idx_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            hit_found_reg   <= 1'b0;
            hit_idx_reg     <= '0;
            hit_rank_reg    <= '0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
            oldest_rank_reg <= '0;
            oldest_idx_reg  <= '0;
        end
        else if (chk_valid_reg)
        begin
            if (chk_match && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= chk_idx_reg;
                hit_rank_reg  <= chk_rank;
            end
            if (!chk_entry_valid && !empty_found_reg)
            begin
                empty_found_reg <= 1'b1;
                empty_idx_reg   <= chk_idx_reg;
            end
            if (chk_rank > oldest_rank_reg)
            begin
                oldest_rank_reg <= chk_rank;
                oldest_idx_reg  <= chk_idx_reg;
            end
        end
    end

    always_comb
    begin
        age_all = 1'b0;
        if (hit_found_reg)
        begin
            frame_sel = hit_idx_reg;
            old_rank  = hit_rank_reg;
        end
        else if (empty_found_reg)
        begin
            frame_sel = empty_idx_reg;
            old_rank  = '0;
            age_all   = 1'b1;
        end
        else
        begin
            frame_sel = oldest_idx_reg;
            old_rank  = oldest_rank_reg;
        end
    end

    // Age valid frames younger than the touched one (all if empty), make it newest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (ctrl.commit)
        begin
            valid_reg[frame_sel] <= 1'b1;
            for (int i = 0; i < FRAMES; i++)
            begin
                if (IDX_W'(i) == frame_sel)
                begin
                    rank_reg[i] <= '0;
                end
                else if (valid_reg[i] && (age_all || (rank_reg[i] < old_rank)))
                begin
                    rank_reg[i] <= rank_reg[i] + 1'b1;
                end
            end
        end
    end

    assign res_hit   = hit_found_reg;
    assign res_frame = frame_sel;

endmodule

`default_nettype wire

/* rtl/lru_page_replacement.sv */
// LRU page replacement table.
// Input channel (in_valid/in_ready, page_number): one page reference per
// transaction. Output channel (out_valid/out_ready): one result per
// reference with hit/fault, the frame now holding the page and four
// saturating 16-bit counts (all hits, all faults, hits and faults of the
// watched page).
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data):
// index 0 frames_in_use, index 1 watched_page; other indices are dropped.
// Write it only while no reference is in flight.
// Flow: a reference is accepted in idle and scanned through the page store,
// one frame per cycle through its single read port; a drain state then
// covers the registered read, and a commit state, which waits for a free
// output register, writes the result. The next reference is accepted only
// once the commit is done and the block is back in idle.
// Reset empties all frames, clears the counts and sets frames_in_use to 16
// and watched_page to 156.
// A stalled receiver holds the result in the output register; the next
// reference is still accepted and scanned, and its commit waits until the
// held result is taken.
`default_nettype none

module lru_page_replacement #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,

    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [lrupr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire  [lrupr_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire  [lrupr_pkg::PAGE_IN_W-1:0]    page_number,

    output logic                               out_valid,
    input  wire                                out_ready,
    output logic                               was_hit,
    output logic [lrupr_pkg::FRAME_OUT_W-1:0]  frame_index,
    output logic [lrupr_pkg::COUNT_W-1:0]      total_hits,
    output logic [lrupr_pkg::COUNT_W-1:0]      total_faults,
    output logic [lrupr_pkg::COUNT_W-1:0]      watched_hits,
    output logic [lrupr_pkg::COUNT_W-1:0]      watched_faults
);

    localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int ACT_W   = (CNT_W > lrupr_pkg::FIU_W) ? CNT_W : lrupr_pkg::FIU_W;
    localparam int EXT_W   = (PAGE_BITS > lrupr_pkg::PAGE_IN_W) ? PAGE_BITS
                                                                 : lrupr_pkg::PAGE_IN_W;
    localparam int FEXT_W  = (IDX_W > lrupr_pkg::FRAME_OUT_W) ? IDX_W
                                                               : lrupr_pkg::FRAME_OUT_W;

    localparam int CW = lrupr_pkg::COUNT_W;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == lrupr_pkg::COUNT_MAX) ? v : v + 1'b1;
    endfunction

    lrupr_pkg::state_t      state_reg;
    lrupr_pkg::state_t      state_next;
    lrupr_pkg::table_ctrl_t ctrl;

    logic [lrupr_pkg::FIU_W-1:0]   fiu_reg;
    logic [lrupr_pkg::WATCH_W-1:0] watch_reg;

    logic [PAGE_BITS-1:0] page_reg;
    logic [IDX_W-1:0]     rd_idx_reg;

    logic [CW-1:0] hit_cnt_reg;
    logic [CW-1:0] fault_cnt_reg;
    logic [CW-1:0] whit_cnt_reg;
    logic [CW-1:0] wfault_cnt_reg;
    logic [CW-1:0] hit_cnt_next;
    logic [CW-1:0] fault_cnt_next;
    logic [CW-1:0] whit_cnt_next;
    logic [CW-1:0] wfault_cnt_next;

    logic                  out_valid_reg;
    logic                  was_hit_reg;
    logic [FEXT_W-1:0]     frame_ext_reg;
    logic [CW-1:0]         total_hits_reg;
    logic [CW-1:0]         total_faults_reg;
    logic [CW-1:0]         watched_hits_reg;
    logic [CW-1:0]         watched_faults_reg;

    logic [ACT_W-1:0]     fiu_ext;
    logic [ACT_W-1:0]     active_wide;
    logic [CNT_W-1:0]     active;
    logic                 scan_last;
    logic [EXT_W-1:0]     page_ext;
    logic [EXT_W-1:0]     watch_ext;
    logic [PAGE_BITS-1:0] page_in;
    logic [PAGE_BITS-1:0] watch_page;
    logic                 is_watched;
    logic                 out_free;
    logic                 res_hit;
    logic [IDX_W-1:0]     res_frame;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg   <= lrupr_pkg::FIU_RESET;
            watch_reg <= lrupr_pkg::WATCH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lrupr_pkg::CFG_FRAMES_IN_USE:
                begin
                    fiu_reg <= cfg_data[lrupr_pkg::FIU_W-1:0];
                end
                lrupr_pkg::CFG_WATCHED_PAGE:
                begin
                    watch_reg <= cfg_data[lrupr_pkg::WATCH_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Clamp the active frame count to 1 .. FRAMES
    always_comb
    begin
        fiu_ext = ACT_W'(fiu_reg);
        if (fiu_ext == '0)
        begin
            active_wide = ACT_W'(1);
        end
        else if (fiu_ext > ACT_W'(FRAMES))
        begin
            active_wide = ACT_W'(FRAMES);
        end
        else
        begin
            active_wide = fiu_ext;
        end
    end

    assign active    = active_wide[CNT_W-1:0];
    assign scan_last = (CNT_W'(rd_idx_reg) == (active - 1'b1));

    assign page_ext   = EXT_W'(page_number);
    assign watch_ext  = EXT_W'(watch_reg);
    assign page_in    = page_ext[PAGE_BITS-1:0];
    assign watch_page = watch_ext[PAGE_BITS-1:0];
    assign is_watched = (page_reg == watch_page);

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lrupr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lrupr_pkg::ST_SCAN;
                end
            end
            lrupr_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = lrupr_pkg::ST_DRAIN;
                end
            end
            lrupr_pkg::ST_DRAIN:
            begin
                state_next = lrupr_pkg::ST_COMMIT;
            end
            lrupr_pkg::ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = lrupr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrupr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        ctrl.start  = 1'b0;
        ctrl.issue  = 1'b0;
        ctrl.commit = 1'b0;
        unique case (state_reg)
            lrupr_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                ctrl.start = in_valid;
            end
            lrupr_pkg::ST_SCAN:
            begin
                ctrl.issue = 1'b1;
            end
            lrupr_pkg::ST_DRAIN:
            begin
            end
            lrupr_pkg::ST_COMMIT:
            begin
                ctrl.commit = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lrupr_pkg::ST_IDLE;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.start)
            begin
                rd_idx_reg <= '0;
            end
            else if (ctrl.issue && !scan_last)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            page_reg <= page_in;
        end
    end

    lrupr_table #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .rd_addr   (rd_idx_reg),
        .page      (page_reg),
        .res_hit   (res_hit),
        .res_frame (res_frame)
    );

    always_comb
    begin
        hit_cnt_next    = hit_cnt_reg;
        fault_cnt_next  = fault_cnt_reg;
        whit_cnt_next   = whit_cnt_reg;
        wfault_cnt_next = wfault_cnt_reg;
        if (res_hit)
        begin
            hit_cnt_next = sat_inc(hit_cnt_reg);
            if (is_watched)
            begin
                whit_cnt_next = sat_inc(whit_cnt_reg);
            end
        end
        else
        begin
            fault_cnt_next = sat_inc(fault_cnt_reg);
            if (is_watched)
            begin
                wfault_cnt_next = sat_inc(wfault_cnt_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg    <= '0;
            fault_cnt_reg  <= '0;
            whit_cnt_reg   <= '0;
            wfault_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.commit)
            begin
                hit_cnt_reg    <= hit_cnt_next;
                fault_cnt_reg  <= fault_cnt_next;
                whit_cnt_reg   <= whit_cnt_next;
                wfault_cnt_reg <= wfault_cnt_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            was_hit_reg        <= res_hit;
            frame_ext_reg      <= FEXT_W'(res_frame);
            total_hits_reg     <= hit_cnt_next;
            total_faults_reg   <= fault_cnt_next;
            watched_hits_reg   <= whit_cnt_next;
            watched_faults_reg <= wfault_cnt_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign was_hit        = was_hit_reg;
    assign frame_index    = frame_ext_reg[lrupr_pkg::FRAME_OUT_W-1:0];
    assign total_hits     = total_hits_reg;
    assign total_faults   = total_faults_reg;
    assign watched_hits   = watched_hits_reg;
    assign watched_faults = watched_faults_reg;

endmodule

`default_nettype wire
